/* rtl/core/tlbpt_pkg.sv */
// Shared constants, types and state codes of the page table translator.
// Used by tlbpt_front, tlbpt_back and tlb_page_table_translator; no dependencies.
package tlbpt_pkg;

   localparam int OFFSET_WIDTH = 10;
   localparam int PAGE_COUNT   = 1024;
   localparam int FRAME_COUNT  = 256;
   localparam int TLB_ENTRIES  = 16;

   localparam int VA_W    = 20;
   localparam int PAGE_W  = $clog2(PAGE_COUNT);
   localparam int FRAME_W = $clog2(FRAME_COUNT);
   localparam int PA_W    = FRAME_W + OFFSET_WIDTH;

   // clearing pass covers the larger of the page table and the frame tables
   localparam int CLR_DEPTH = (PAGE_COUNT > FRAME_COUNT) ? PAGE_COUNT : FRAME_COUNT;
   localparam int CLR_W     = $clog2(CLR_DEPTH);

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic POLICY_FIFO = 1'b0;
   localparam logic POLICY_LRU  = 1'b1;

   typedef struct packed {
      logic [PAGE_W-1:0]       page;
      logic [OFFSET_WIDTH-1:0] offset;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_out_type;

   typedef struct packed {
      logic pop;
      logic clearing;
   } back_status_type;

   typedef enum logic [7:0] {
      ST_CLEAR = 8'b0000_0001,
      ST_IDLE  = 8'b0000_0010,
      ST_PTRD  = 8'b0000_0100,
      ST_OWN   = 8'b0000_1000,
      ST_TRD   = 8'b0001_0000,
      ST_W1    = 8'b0010_0000,
      ST_W2    = 8'b0100_0000
   } state_type;

endpackage

/* rtl/core/tlbpt_front.sv */
// Front end: accepts request transactions, splits the address, queues them.
// Depends on tlbpt_pkg.
module tlbpt_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [tlbpt_pkg::VA_W-1:0] req_virtual_address,
   input  tlbpt_pkg::back_status_type status,
   output tlbpt_pkg::queue_out_type   queue_out
);

   tlbpt_pkg::item_type             q_mem_ff [tlbpt_pkg::QUEUE_DEPTH];
   logic [tlbpt_pkg::QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [tlbpt_pkg::QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [tlbpt_pkg::QCNT_W-1:0]    cnt_ff, cnt_in;
   logic                            push;
   logic                            pop;
   tlbpt_pkg::item_type             item;

   // split the address into page and offset
   assign item.offset = req_virtual_address[tlbpt_pkg::OFFSET_WIDTH-1:0];
   assign item.page   = req_virtual_address[tlbpt_pkg::OFFSET_WIDTH +: tlbpt_pkg::PAGE_W];

   // hold off requests while full or while the tables are cleared
   assign busy = status.clearing ||
                 (cnt_ff == tlbpt_pkg::QCNT_W'(tlbpt_pkg::QUEUE_DEPTH));
   assign push = start && !busy;
   assign pop  = status.pop && (cnt_ff != '0);

   assign queue_out.valid = (cnt_ff != '0);
   assign queue_out.item  = q_mem_ff[rd_ptr_ff];

   // advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // store the queued item
   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= item;
      end
   end

endmodule

/* rtl/core/tlbpt_back.sv */
// Back end: TLB, page table, frame owner table and LRU recency list sequencer.
// Depends on tlbpt_pkg.
module tlbpt_back #(
   parameter int TLB_ENTRIES = tlbpt_pkg::TLB_ENTRIES
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                policy,
   input  tlbpt_pkg::queue_out_type            queue_out,
   output tlbpt_pkg::back_status_type          status,
   output logic                                rsp_strobe,
   output logic [tlbpt_pkg::PA_W-1:0]          rsp_translated_address,
   output logic                                rsp_tlb_hit,
   output logic                                rsp_page_fault,
   output logic                                rsp_evicted_valid,
   output logic [tlbpt_pkg::PAGE_W-1:0]        rsp_evicted_page
);

   localparam int TLB_W = $clog2(TLB_ENTRIES);
   localparam int PW    = tlbpt_pkg::PAGE_W;
   localparam int FW    = tlbpt_pkg::FRAME_W;
   localparam int CW    = tlbpt_pkg::CLR_W;

   tlbpt_pkg::state_type state_ff, state_in;
   logic [CW-1:0]                   clr_cnt_ff, clr_cnt_in;
   logic [PW-1:0]                   page_ff, page_in;
   logic [tlbpt_pkg::OFFSET_WIDTH-1:0] offset_ff, offset_in;
   logic [FW-1:0]                   frame_ff, frame_in;
   logic                            hit_ff, hit_in;
   logic                            fault_ff, fault_in;
   logic                            evv_ff, evv_in;
   logic [PW-1:0]                   evp_ff, evp_in;
   logic [FW-1:0]                   fifo_ptr_ff, fifo_ptr_in;
   logic [FW-1:0]                   head_ff, head_in;
   logic [FW-1:0]                   tail_ff, tail_in;
   logic                            strobe_ff, strobe_in;

   logic [PW-1:0]                   tag_ff [TLB_ENTRIES];
   logic [PW-1:0]                   tag_in [TLB_ENTRIES];
   logic [FW-1:0]                   frm_ff [TLB_ENTRIES];
   logic [FW-1:0]                   frm_in [TLB_ENTRIES];
   logic [TLB_ENTRIES-1:0]          vld_ff, vld_in;
   logic [TLB_W-1:0]                fill_ff, fill_in;

   logic                            lk_hit;
   logic [FW-1:0]                   lk_frame;
   logic [TLB_ENTRIES-1:0]          rw_match;

   logic [FW:0]                     pt_mem [tlbpt_pkg::PAGE_COUNT];
   logic [PW:0]                     own_mem [tlbpt_pkg::FRAME_COUNT];
   logic [FW-1:0]                   prev_mem [tlbpt_pkg::FRAME_COUNT];
   logic [FW-1:0]                   next_mem [tlbpt_pkg::FRAME_COUNT];
   logic [FW:0]                     pt_rd_ff;
   logic [PW:0]                     own_rd_ff;
   logic [FW-1:0]                   prev_rd_ff, next_rd_ff;

   logic                            pt_we, pt_re;
   logic [PW-1:0]                   pt_wa, pt_ra;
   logic [FW:0]                     pt_wd;
   logic                            own_we, own_re;
   logic [FW-1:0]                   own_wa, own_ra;
   logic [PW:0]                     own_wd;
   logic                            prev_we, next_we, lnk_re;
   logic [FW-1:0]                   prev_wa, next_wa, lnk_ra;
   logic [FW-1:0]                   prev_wd, next_wd;
   logic                            pop;

   // look up the queued page, lowest matching entry wins
   always_comb begin
      lk_hit   = 1'b0;
      lk_frame = '0;
      for (int k = TLB_ENTRIES - 1; k >= 0; k--) begin
         if (vld_ff[k] && (tag_ff[k] == queue_out.item.page)) begin
            lk_hit   = 1'b1;
            lk_frame = frm_ff[k];
         end
      end
   end

   // find entries that point at the victim frame
   always_comb begin
      for (int k = 0; k < TLB_ENTRIES; k++) begin
         rw_match[k] = vld_ff[k] && (frm_ff[k] == frame_ff);
      end
   end

   // sequence one transaction
   always_comb begin
      state_in    = state_ff;
      clr_cnt_in  = clr_cnt_ff;
      page_in     = page_ff;
      offset_in   = offset_ff;
      frame_in    = frame_ff;
      hit_in      = hit_ff;
      fault_in    = fault_ff;
      evv_in      = evv_ff;
      evp_in      = evp_ff;
      fifo_ptr_in = fifo_ptr_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      strobe_in   = 1'b0;
      vld_in      = vld_ff;
      fill_in     = fill_ff;
      for (int k = 0; k < TLB_ENTRIES; k++) begin
         tag_in[k] = tag_ff[k];
         frm_in[k] = frm_ff[k];
      end
      pop     = 1'b0;
      pt_we   = 1'b0;
      pt_wa   = '0;
      pt_wd   = '0;
      pt_re   = 1'b0;
      pt_ra   = '0;
      own_we  = 1'b0;
      own_wa  = '0;
      own_wd  = '0;
      own_re  = 1'b0;
      own_ra  = '0;
      prev_we = 1'b0;
      prev_wa = '0;
      prev_wd = '0;
      next_we = 1'b0;
      next_wa = '0;
      next_wd = '0;
      lnk_re  = 1'b0;
      lnk_ra  = '0;

      case (state_ff)
         tlbpt_pkg::ST_CLEAR: begin
            // clear mapped and owned bits, build the initial recency list
            pt_we   = ((CW + 1)'(clr_cnt_ff) < (CW + 1)'(tlbpt_pkg::PAGE_COUNT));
            pt_wa   = clr_cnt_ff[PW-1:0];
            own_we  = ((CW + 1)'(clr_cnt_ff) < (CW + 1)'(tlbpt_pkg::FRAME_COUNT));
            own_wa  = clr_cnt_ff[FW-1:0];
            prev_we = own_we;
            prev_wa = clr_cnt_ff[FW-1:0];
            prev_wd = clr_cnt_ff[FW-1:0] + 1'b1;
            next_we = own_we;
            next_wa = clr_cnt_ff[FW-1:0];
            next_wd = clr_cnt_ff[FW-1:0] - 1'b1;
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == CW'(tlbpt_pkg::CLR_DEPTH - 1)) begin
               state_in = tlbpt_pkg::ST_IDLE;
            end
         end
         tlbpt_pkg::ST_IDLE: begin
            if (queue_out.valid) begin
               pop       = 1'b1;
               page_in   = queue_out.item.page;
               offset_in = queue_out.item.offset;
               fault_in  = 1'b0;
               evv_in    = 1'b0;
               evp_in    = '0;
               if (policy == tlbpt_pkg::POLICY_LRU) begin
                  fifo_ptr_in = tail_ff;
               end
               if (lk_hit) begin
                  hit_in   = 1'b1;
                  frame_in = lk_frame;
                  state_in = tlbpt_pkg::ST_TRD;
               end else begin
                  hit_in   = 1'b0;
                  pt_re    = 1'b1;
                  pt_ra    = queue_out.item.page;
                  state_in = tlbpt_pkg::ST_PTRD;
               end
            end
         end
         tlbpt_pkg::ST_PTRD: begin
            if (pt_rd_ff[FW]) begin
               // page table hit: refill the TLB
               frame_in        = pt_rd_ff[FW-1:0];
               tag_in[fill_ff] = page_ff;
               frm_in[fill_ff] = pt_rd_ff[FW-1:0];
               vld_in[fill_ff] = 1'b1;
               fill_in  = (fill_ff == TLB_W'(TLB_ENTRIES - 1)) ? '0 : fill_ff + 1'b1;
               state_in = tlbpt_pkg::ST_TRD;
            end else begin
               fault_in = 1'b1;
               frame_in = fifo_ptr_ff;
               own_re   = 1'b1;
               own_ra   = fifo_ptr_ff;
               state_in = tlbpt_pkg::ST_OWN;
            end
         end
         tlbpt_pkg::ST_OWN: begin
            // unmap the old owner, claim the frame, fix up the TLB
            if (own_rd_ff[PW]) begin
               evv_in = 1'b1;
               evp_in = own_rd_ff[PW-1:0];
               pt_we  = 1'b1;
               pt_wa  = own_rd_ff[PW-1:0];
               pt_wd  = '0;
            end
            own_we = 1'b1;
            own_wa = frame_ff;
            own_wd = {1'b1, page_ff};
            if (rw_match != '0) begin
               for (int k = 0; k < TLB_ENTRIES; k++) begin
                  if (rw_match[k]) begin
                     tag_in[k] = page_ff;
                  end
               end
            end else begin
               tag_in[fill_ff] = page_ff;
               frm_in[fill_ff] = frame_ff;
               vld_in[fill_ff] = 1'b1;
               fill_in = (fill_ff == TLB_W'(TLB_ENTRIES - 1)) ? '0 : fill_ff + 1'b1;
            end
            if (policy == tlbpt_pkg::POLICY_FIFO) begin
               fifo_ptr_in = (frame_ff == FW'(tlbpt_pkg::FRAME_COUNT - 1)) ? '0 :
                             frame_ff + 1'b1;
            end
            state_in = tlbpt_pkg::ST_TRD;
         end
         tlbpt_pkg::ST_TRD: begin
            // map the faulted page, read the frame's list neighbors
            if (fault_ff) begin
               pt_we = 1'b1;
               pt_wa = page_ff;
               pt_wd = {1'b1, frame_ff};
            end
            lnk_re   = 1'b1;
            lnk_ra   = frame_ff;
            state_in = tlbpt_pkg::ST_W1;
         end
         tlbpt_pkg::ST_W1: begin
            // unlink the frame from the recency list
            if (frame_ff != head_ff) begin
               if (frame_ff == tail_ff) begin
                  tail_in = prev_rd_ff;
               end else begin
                  prev_we = 1'b1;
                  prev_wa = next_rd_ff;
                  prev_wd = prev_rd_ff;
               end
               next_we = 1'b1;
               next_wa = prev_rd_ff;
               next_wd = next_rd_ff;
            end
            state_in = tlbpt_pkg::ST_W2;
         end
         tlbpt_pkg::ST_W2: begin
            // link the frame in as most recent and report
            if (frame_ff != head_ff) begin
               next_we = 1'b1;
               next_wa = frame_ff;
               next_wd = head_ff;
               prev_we = 1'b1;
               prev_wa = head_ff;
               prev_wd = frame_ff;
               head_in = frame_ff;
            end
            strobe_in = 1'b1;
            state_in  = tlbpt_pkg::ST_IDLE;
         end
         default: begin
            state_in = tlbpt_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= tlbpt_pkg::ST_CLEAR;
         clr_cnt_ff  <= '0;
         fifo_ptr_ff <= '0;
         head_ff     <= FW'(tlbpt_pkg::FRAME_COUNT - 1);
         tail_ff     <= '0;
         strobe_ff   <= 1'b0;
         vld_ff      <= '0;
         fill_ff     <= '0;
      end else begin
         state_ff    <= state_in;
         clr_cnt_ff  <= clr_cnt_in;
         fifo_ptr_ff <= fifo_ptr_in;
         head_ff     <= head_in;
         tail_ff     <= tail_in;
         strobe_ff   <= strobe_in;
         vld_ff      <= vld_in;
         fill_ff     <= fill_in;
      end
   end

   // hold transaction payload and TLB contents
   always_ff @(posedge clock) begin
      page_ff   <= page_in;
      offset_ff <= offset_in;
      frame_ff  <= frame_in;
      hit_ff    <= hit_in;
      fault_ff  <= fault_in;
      evv_ff    <= evv_in;
      evp_ff    <= evp_in;
      for (int k = 0; k < TLB_ENTRIES; k++) begin
         tag_ff[k] <= tag_in[k];
         frm_ff[k] <= frm_in[k];
      end
   end

   // page table memory
   always_ff @(posedge clock) begin
      if (pt_we) begin
         pt_mem[pt_wa] <= pt_wd;
      end
      if (pt_re) begin
         pt_rd_ff <= pt_mem[pt_ra];
      end
   end

   // frame owner memory
   always_ff @(posedge clock) begin
      if (own_we) begin
         own_mem[own_wa] <= own_wd;
      end
      if (own_re) begin
         own_rd_ff <= own_mem[own_ra];
      end
   end

   // recency list memories
   always_ff @(posedge clock) begin
      if (prev_we) begin
         prev_mem[prev_wa] <= prev_wd;
      end
      if (lnk_re) begin
         prev_rd_ff <= prev_mem[lnk_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (next_we) begin
         next_mem[next_wa] <= next_wd;
      end
      if (lnk_re) begin
         next_rd_ff <= next_mem[lnk_ra];
      end
   end

   assign status.pop      = pop;
   assign status.clearing = (state_ff == tlbpt_pkg::ST_CLEAR);

   assign rsp_strobe             = strobe_ff;
   assign rsp_translated_address = {frame_ff, offset_ff};
   assign rsp_tlb_hit            = hit_ff;
   assign rsp_page_fault         = fault_ff;
   assign rsp_evicted_valid      = evv_ff;
   assign rsp_evicted_page       = evp_ff;

endmodule

/* rtl/core/tlb_page_table_translator.sv */
// Top level of the TLB and demand paging address translator.
// Depends on tlbpt_pkg, tlbpt_front and tlbpt_back.
//
// Usage:
//   Request: drive req_virtual_address and raise start; the transaction is taken
//   at a rising edge with start high and busy low. Upper bits give the page,
//   the low OFFSET_WIDTH bits the offset.
//   Response: one transaction per request, on the rsp_ ports for exactly one
//   cycle while rsp_strobe is high. The receiver cannot stall the block.
//   Configuration: csr_write_enable with csr_write_data selects FIFO (0) or
//   LRU (1) frame replacement; write only while the block is idle.
//   One transaction is worked on at a time: the back end takes no new request
//   until it has sent the response of the last one. In the page table, owner
//   and recency list memories the read of each precedes its update.
//   A two-entry queue takes requests while the back end works.
//   Reset: a clearing pass walks the 1024 memory addresses, clearing the
//   mapped and owned bits and building the recency list; busy is high during
//   the pass.
module tlb_page_table_translator #(
   parameter int TLB_ENTRIES = tlbpt_pkg::TLB_ENTRIES
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [tlbpt_pkg::VA_W-1:0]    req_virtual_address,
   input  logic                          csr_write_enable,
   input  logic                          csr_write_data,
   output logic                          rsp_strobe,
   output logic [tlbpt_pkg::PA_W-1:0]    rsp_translated_address,
   output logic                          rsp_tlb_hit,
   output logic                          rsp_page_fault,
   output logic                          rsp_evicted_valid,
   output logic [tlbpt_pkg::PAGE_W-1:0]  rsp_evicted_page
);

   logic                       policy_ff;
   tlbpt_pkg::queue_out_type   queue_out;
   tlbpt_pkg::back_status_type status;

   // hold the replacement policy register
   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff <= tlbpt_pkg::POLICY_FIFO;
      end else if (csr_write_enable) begin
         policy_ff <= csr_write_data;
      end
   end

   tlbpt_front u_front (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_virtual_address (req_virtual_address),
      .status              (status),
      .queue_out           (queue_out)
   );

   tlbpt_back #(
      .TLB_ENTRIES (TLB_ENTRIES)
   ) u_back (
      .clock                  (clock),
      .reset                  (reset),
      .policy                 (policy_ff),
      .queue_out              (queue_out),
      .status                 (status),
      .rsp_strobe             (rsp_strobe),
      .rsp_translated_address (rsp_translated_address),
      .rsp_tlb_hit            (rsp_tlb_hit),
      .rsp_page_fault         (rsp_page_fault),
      .rsp_evicted_valid      (rsp_evicted_valid),
      .rsp_evicted_page       (rsp_evicted_page)
   );

   // the strobe comes only from ST_W2, reached through ST_TRD and ST_W1, so strobes never touch
   a_strobe_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe) else $error("back-to-back response strobes");

   a_hit_no_fault: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !(rsp_tlb_hit && rsp_page_fault))
      else $error("TLB hit reported with a page fault");

   a_evict_on_fault: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_evicted_valid) |-> rsp_page_fault)
      else $error("eviction without a page fault");

   a_no_rsp_in_clear: assert property (@(posedge clock) disable iff (reset)
      status.clearing |-> (busy && !rsp_strobe))
      else $error("activity during the clearing pass");

endmodule

/* dv/tlb_page_table_translator_checker.sv */
// Checker of the page table translator: watches the request, response and
// configuration ports, predicts each response and compares it. Uses tlbpt_pkg.
module tlb_page_table_translator_checker
   import tlbpt_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic                    busy,
   input  logic [VA_W-1:0]         req_virtual_address,
   input  logic                    csr_write_enable,
   input  logic                    csr_write_data,
   input  logic                    rsp_strobe,
   input  logic [PA_W-1:0]         rsp_translated_address,
   input  logic                    rsp_tlb_hit,
   input  logic                    rsp_page_fault,
   input  logic                    rsp_evicted_valid,
   input  logic [PAGE_W-1:0]       rsp_evicted_page,
   output int                      fail_count,
   output int                      pending_count
);

   typedef struct packed {
      logic [PA_W-1:0]   phys;
      logic              hit;
      logic              fault;
      logic              ev_valid;
      logic [PAGE_W-1:0] ev_page;
   } translation_type;

   translation_type     expected_translations[$];

   // shadow copy of the translator state
   logic [PAGE_W-1:0]   tag_shadow[TLB_ENTRIES];
   logic [FRAME_W-1:0]  tlb_frame_shadow[TLB_ENTRIES];
   logic                tlb_valid_shadow[TLB_ENTRIES];
   logic [3:0]          fill_ptr;
   logic [FRAME_W-1:0]  page_frame[PAGE_COUNT];
   logic                page_is_mapped[PAGE_COUNT];
   logic [PAGE_W-1:0]   owner_page[FRAME_COUNT];
   logic                frame_is_owned[FRAME_COUNT];
   logic [FRAME_W-1:0]  victim_ptr;
   logic [FRAME_W-1:0]  recency[FRAME_COUNT];
   logic                policy;

   function automatic void touch(input logic [FRAME_W-1:0] f);
      logic [FRAME_W-1:0] a;
      a = recency[f];
      for (int k = 0; k < FRAME_COUNT; k++)
         if (recency[k] < a) recency[k] = recency[k] + 1'b1;
      recency[f] = '0;
   endfunction

   function automatic void tlb_fill(input logic [PAGE_W-1:0] pg, input logic [FRAME_W-1:0] f);
      tag_shadow[fill_ptr]       = pg;
      tlb_frame_shadow[fill_ptr] = f;
      tlb_valid_shadow[fill_ptr] = 1'b1;
      fill_ptr                   = fill_ptr + 1'b1;
   endfunction

   function automatic translation_type translate(input logic [VA_W-1:0] va);
      translation_type    t;
      logic [PAGE_W-1:0]  pg;
      logic [FRAME_W-1:0] f;
      logic               rewritten;
      t  = '0;
      pg = va[VA_W-1:OFFSET_WIDTH];
      f  = '0;
      rewritten = 1'b0;
      // LRU: aim the victim pointer at the oldest frame
      if (policy == POLICY_LRU)
         for (int k = 0; k < FRAME_COUNT; k++)
            if (recency[k] == FRAME_W'(FRAME_COUNT - 1)) victim_ptr = FRAME_W'(k);
      for (int k = 0; k < TLB_ENTRIES; k++)
         if (!t.hit && tlb_valid_shadow[k] && tag_shadow[k] == pg) begin
            t.hit = 1'b1;
            f = tlb_frame_shadow[k];
         end
      if (t.hit) begin
         touch(f);
      end else if (page_is_mapped[pg]) begin
         f = page_frame[pg];
         touch(f);
         tlb_fill(pg, f);
      end else begin
         t.fault = 1'b1;
         f = victim_ptr;
         if (frame_is_owned[f]) begin
            t.ev_valid = 1'b1;
            t.ev_page  = owner_page[f];
            page_is_mapped[owner_page[f]] = 1'b0;
         end
         // retag any entry that still points at the victim frame
         for (int k = 0; k < TLB_ENTRIES; k++)
            if (tlb_valid_shadow[k] && tlb_frame_shadow[k] == f) begin
               tag_shadow[k] = pg;
               rewritten = 1'b1;
            end
         if (!rewritten) tlb_fill(pg, f);
         page_frame[pg]     = f;
         page_is_mapped[pg] = 1'b1;
         owner_page[f]      = pg;
         frame_is_owned[f]  = 1'b1;
         touch(f);
         if (policy == POLICY_FIFO) victim_ptr = f + 1'b1;
      end
      t.phys = {f, va[OFFSET_WIDTH-1:0]};
      return t;
   endfunction

   assign pending_count = expected_translations.size();

   always @(posedge clock) begin
      translation_type exp_t;
      if (reset) begin
         for (int k = 0; k < TLB_ENTRIES; k++) begin
            tag_shadow[k] = '0;
            tlb_frame_shadow[k] = '0;
            tlb_valid_shadow[k] = 1'b0;
         end
         for (int k = 0; k < PAGE_COUNT; k++) begin
            page_is_mapped[k] = 1'b0;
            page_frame[k] = '0;
         end
         for (int k = 0; k < FRAME_COUNT; k++) begin
            frame_is_owned[k] = 1'b0;
            owner_page[k] = '0;
            recency[k] = FRAME_W'(FRAME_COUNT - 1 - k);
         end
         fill_ptr   = '0;
         victim_ptr = '0;
         policy     = POLICY_FIFO;
         fail_count = 0;
         expected_translations.delete();
      end else begin
         if (csr_write_enable) policy = csr_write_data;
         // check a response against the oldest prediction
         if (rsp_strobe) begin
            if (expected_translations.size() == 0) begin
               $error("unexpected response transaction");
               fail_count++;
            end else begin
               exp_t = expected_translations.pop_front();
               if (rsp_translated_address !== exp_t.phys) begin
                  $error("translated_address expected %0h actual %0h",
                         exp_t.phys, rsp_translated_address);
                  fail_count++;
               end
               if (rsp_tlb_hit !== exp_t.hit) begin
                  $error("tlb_hit expected %0d actual %0d", exp_t.hit, rsp_tlb_hit);
                  fail_count++;
               end
               if (rsp_page_fault !== exp_t.fault) begin
                  $error("page_fault expected %0d actual %0d", exp_t.fault, rsp_page_fault);
                  fail_count++;
               end
               if (rsp_evicted_valid !== exp_t.ev_valid) begin
                  $error("evicted_valid expected %0d actual %0d",
                         exp_t.ev_valid, rsp_evicted_valid);
                  fail_count++;
               end
               if (rsp_evicted_page !== exp_t.ev_page) begin
                  $error("evicted_page expected %0h actual %0h",
                         exp_t.ev_page, rsp_evicted_page);
                  fail_count++;
               end
            end
         end
         // predict each accepted request transaction
         if (start && !busy)
            expected_translations.push_back(translate(req_virtual_address));
      end
   end

endmodule

/* dv/tlb_page_table_translator_tb.sv */
// Testbench top of the page table translator: clock, reset, stimulus and verdict.
// Depends on tlbpt_pkg, tlb_page_table_translator and its checker.
module tlb_page_table_translator_tb;
   import tlbpt_pkg::*;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic [VA_W-1:0]   req_virtual_address = '0;
   logic              csr_write_enable = 1'b0;
   logic              csr_write_data = 1'b0;
   logic              rsp_strobe;
   logic [PA_W-1:0]   rsp_translated_address;
   logic              rsp_tlb_hit;
   logic              rsp_page_fault;
   logic              rsp_evicted_valid;
   logic [PAGE_W-1:0] rsp_evicted_page;
   int                fail_count;
   int                pending_count;
   int                idle_pct;

   always #10 clock = ~clock;

   tlb_page_table_translator dut (.*);
   tlb_page_table_translator_checker checker_inst (.*);

   // issue one transaction and return once it is taken
   task automatic send_address(input logic [VA_W-1:0] va);
      req_virtual_address = va;
      start = 1'b1;
      while (busy) @(negedge clock);
      @(negedge clock);
      if ($urandom_range(99) < idle_pct) begin
         start = 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
   endtask

   // drain all responses, then write the policy while idle
   task automatic set_policy(input logic p);
      start = 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      csr_write_enable = 1'b1;
      csr_write_data = p;
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   function automatic logic [VA_W-1:0] pick_address();
      int sel;
      logic [PAGE_W-1:0] pg;
      sel = $urandom_range(99);
      if (sel < 35) pg = PAGE_W'($urandom_range(0, 19));
      else if (sel < 70) pg = PAGE_W'($urandom_range(0, 299));
      else pg = PAGE_W'($urandom());
      return {pg, OFFSET_WIDTH'($urandom())};
   endfunction

   initial begin
      repeat (8) @(negedge clock);
      reset = 1'b0;
      idle_pct = 0;
      set_policy(POLICY_FIFO);
      // directed: field extremes, TLB hit, table hit, faults
      send_address('0);
      send_address('0);
      send_address(20'hFFFFF);
      send_address(20'hFFC00);
      send_address(20'h003FF);
      send_address(20'h00400);
      for (int k = 0; k < 16; k++) send_address({PAGE_W'(k + 2), OFFSET_WIDTH'(k)});
      send_address(20'h00001);
      send_address(20'hFFFFF);
      set_policy(POLICY_LRU);
      send_address(20'h00800);
      send_address(20'h00005);
      // random phases with varying idling and policy
      for (int ph = 0; ph < 4; ph++) begin
         idle_pct = (ph == 0) ? 0 : (ph == 1) ? 72 : (ph == 2) ? 31 : 50;
         set_policy(ph[0]);
         for (int n = 0; n < 460; n++) send_address(pick_address());
      end
      start = 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (fail_count == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      #8000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
